/* src/dfn_pkg.sv */
// Package: types, character codes and helpers shared by the decimal field normalizer.
package dfn_pkg;

  localparam int unsigned MaxScale = 15;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [3:0] FracScaleRst = 4'd2;
  localparam logic [4:0] MaxIntRst    = 5'd18;
  localparam logic       AllowZeroRst = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_PLUS  = 2'd1,
    PH_BODY  = 2'd2,
    PH_TRAIL = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NEGATIVE = 3'd2,
    ST_INVALID  = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_TOO_FRAC = 3'd5,
    ST_ZERO     = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CFG_FRAC_SCALE = 2'd0,
    CFG_MAX_INT    = 2'd1,
    CFG_ALLOW_ZERO = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic content;
    logic dot;
    logic neg;
    logic inval;
    logic nzint;
    logic nzfrac;
  } flags_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
           (c == 8'h0C) || (c == 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  // Clamp the configured scale to the largest supported one.
  function automatic logic [3:0] eff_scale(input logic [3:0] scale);
    return ({1'b0, scale} > 5'(MaxScale)) ? 4'(MaxScale) : scale;
  endfunction

  // Integer length counts an empty integer part as one digit.
  function automatic logic int_too_long(input logic [5:0] cnt, input logic [4:0] max_int);
    logic [5:0] len;
    len = (cnt == 6'd0) ? 6'd1 : cnt;
    return len > {1'b0, max_int};
  endfunction

endpackage

/* src/dfn_if.sv */
// Interfaces: byte request channel and normalized result channel.
interface dfn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_empty;
  logic       last;

  modport source (output valid, output in_char, output is_empty, output last, input ready);
  modport sink   (input valid, input in_char, input is_empty, input last, output ready);
endinterface

interface dfn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       end_of_field;
  logic [2:0] status;

  modport source (output valid, output out_char, output char_valid, output end_of_field,
                  output status, input ready);
  modport sink   (input valid, input out_char, input char_valid, input end_of_field,
                  input status, output ready);
endinterface

/* src/decimal_field_normalizer.sv */
// Top level: decimal text field normalizer with byte input and result stream output.
//
//  channel | dir | payload                                   | handshake
//  --------+-----+-------------------------------------------+-----------
//  in_i    | in  | in_char[8], is_empty, last                | valid/ready
//  out_o   | out | out_char[8], char_valid, end_of_field,    | valid/ready
//          |     | status[3]                                 |
//  cfg     | in  | cfg_we_i, cfg_idx_i[2], cfg_wdata_i[5]    | write only
//
// A byte is parsed in the cycle it is accepted and its results land in a plan register.
// The plan drains one result per cycle while the output is not stalled: up to two text
// bytes, then padding zeros, then the status item on a field's final request.
// A new request is taken in the cycle the plan's final result is taken.
// Reset is asynchronous, active low; it clears the parse state and the plan valid and counts,
// and loads the config defaults. Output stalls hold the plan and back-pressure the input.
module decimal_field_normalizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  dfn_in_if.sink           in_i,
  dfn_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [4:0]       cfg_wdata_i
);

  // Configuration registers
  logic [3:0] frac_scale_q;
  logic [4:0] max_int_q;
  logic       allow_zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_scale_q <= dfn_pkg::FracScaleRst;
      max_int_q    <= dfn_pkg::MaxIntRst;
      allow_zero_q <= dfn_pkg::AllowZeroRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfn_pkg::CFG_FRAC_SCALE: frac_scale_q <= cfg_wdata_i[3:0];
        dfn_pkg::CFG_MAX_INT:    max_int_q    <= cfg_wdata_i;
        dfn_pkg::CFG_ALLOW_ZERO: allow_zero_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Parse state
  dfn_pkg::phase_e phase_q, phase_d;
  logic [5:0]      int_cnt_q, int_cnt_d;
  logic [4:0]      frac_cnt_q, frac_cnt_d;
  dfn_pkg::flags_t flags_q, flags_d;

  // Plan register
  logic            pv_q;
  logic [1:0]      nc_q;
  logic [7:0]      c0_q, c1_q;
  logic [3:0]      pad_q;
  logic            fin_q;
  dfn_pkg::status_e st_q;

  logic [7:0] ch;
  logic       ws;
  logic       in_fire, out_fire, last_beat, finish;
  logic [4:0] remain;

  assign ch      = in_i.in_char;
  assign ws      = dfn_pkg::is_ws(ch);
  assign finish  = in_i.is_empty | in_i.last;

  assign remain    = 5'(nc_q) + 5'(pad_q) + 5'(fin_q);
  assign last_beat = (remain == 5'd1);
  assign out_fire  = pv_q & out_o.ready;
  assign in_i.ready = ~pv_q | (out_fire & last_beat);
  assign in_fire   = in_i.valid & in_i.ready;

  // Phase sequencing
  dfn_pkg::phase_e ph_n;
  logic            first_c, run_body, trail_bad;

  always_comb begin
    ph_n      = phase_q;
    first_c   = 1'b0;
    run_body  = 1'b0;
    trail_bad = 1'b0;
    unique case (phase_q)
      dfn_pkg::PH_LEAD: begin
        if (!ws) begin
          if (ch == dfn_pkg::ChPlus) ph_n = dfn_pkg::PH_PLUS;
          else                       first_c = 1'b1;
        end
      end
      dfn_pkg::PH_PLUS: begin
        if (ws) ph_n = dfn_pkg::PH_TRAIL;
        else    first_c = 1'b1;
      end
      dfn_pkg::PH_BODY: begin
        if (ws) ph_n = dfn_pkg::PH_TRAIL;
        else    run_body = 1'b1;
      end
      dfn_pkg::PH_TRAIL: begin
        trail_bad = ~ws;
      end
      default: ;
    endcase
    if (first_c) ph_n = dfn_pkg::PH_BODY;
  end

  // Byte datapath
  dfn_pkg::flags_t fl_n, fl_f;
  logic [5:0]      ic_n, ic_f;
  logic [4:0]      fc_n, fc_f;
  logic            do_body, b_dot, b_zero, b_dig, err_n;
  logic [1:0]      b_cnt, p_cnt;
  logic [7:0]      b0, b1, p0, p1;
  logic [3:0]      scale;
  dfn_pkg::status_e st;
  logic [3:0]      pad;
  logic [1:0]      nc;
  logic [7:0]      c0, c1;
  logic            plan_any;

  always_comb begin
    fl_n    = flags_q;
    ic_n    = int_cnt_q;
    fc_n    = frac_cnt_q;
    do_body = run_body;
    b_dot   = 1'b0;
    b_zero  = 1'b0;
    b_dig   = 1'b0;
    if (trail_bad) begin
      fl_n.content = 1'b1;
      fl_n.inval   = 1'b1;
    end
    if (first_c) begin
      fl_n.content = 1'b1;
      if (ch == dfn_pkg::ChMinus) fl_n.neg = 1'b1;
      else                        do_body = 1'b1;
    end
    if (do_body) begin
      if (ch == dfn_pkg::ChDot) begin
        if (fl_n.dot) begin
          fl_n.inval = 1'b1;
        end else begin
          fl_n.dot = 1'b1;
          b_dot    = 1'b1;
          b_zero   = ~fl_n.nzint;
        end
      end else if (dfn_pkg::is_digit(ch)) begin
        if (!fl_n.dot) begin
          // drop leading integer zeros
          if (fl_n.nzint || ch != dfn_pkg::ChZero) begin
            fl_n.nzint = 1'b1;
            ic_n  = (ic_n == 6'd63) ? ic_n : ic_n + 6'd1;
            b_dig = 1'b1;
          end
        end else begin
          fc_n = (fc_n == 5'd31) ? fc_n : fc_n + 5'd1;
          if (ch != dfn_pkg::ChZero) fl_n.nzfrac = 1'b1;
          b_dig = 1'b1;
        end
      end else begin
        fl_n.inval = 1'b1;
      end
    end

    scale = dfn_pkg::eff_scale(frac_scale_q);
    err_n = fl_n.neg | fl_n.inval | dfn_pkg::int_too_long(ic_n, max_int_q) |
            (fc_n > {1'b0, scale});

    // Text bytes from this byte; none once the field is known bad
    b_cnt = 2'd0;
    b0    = dfn_pkg::ChZero;
    b1    = dfn_pkg::ChDot;
    if (!in_i.is_empty && !err_n) begin
      if (b_zero) begin
        b_cnt = 2'd2;
      end else if (b_dot) begin
        b_cnt = 2'd1;
        b0    = dfn_pkg::ChDot;
      end else if (b_dig) begin
        b_cnt = 2'd1;
        b0    = ch;
      end
    end

    // Field end sees the state before this byte on an empty request
    fl_f = in_i.is_empty ? flags_q    : fl_n;
    ic_f = in_i.is_empty ? int_cnt_q  : ic_n;
    fc_f = in_i.is_empty ? frac_cnt_q : fc_n;

    if (!fl_f.content)                                 st = dfn_pkg::ST_EMPTY;
    else if (fl_f.neg)                                 st = dfn_pkg::ST_NEGATIVE;
    else if (fl_f.inval)                               st = dfn_pkg::ST_INVALID;
    else if (dfn_pkg::int_too_long(ic_f, max_int_q))   st = dfn_pkg::ST_TOO_LONG;
    else if (fc_f > {1'b0, scale})                     st = dfn_pkg::ST_TOO_FRAC;
    else if (!allow_zero_q && !(fl_f.nzint || fl_f.nzfrac)) st = dfn_pkg::ST_ZERO;
    else                                               st = dfn_pkg::ST_OK;

    p_cnt = 2'd0;
    p0    = dfn_pkg::ChZero;
    p1    = dfn_pkg::ChDot;
    pad   = 4'd0;
    if (finish && st == dfn_pkg::ST_OK) begin
      if (!fl_f.dot) begin
        if (fl_f.nzint) begin
          p_cnt = 2'd1;
          p0    = dfn_pkg::ChDot;
        end else begin
          p_cnt = 2'd2;
        end
      end
      pad = 4'({1'b0, scale} - fc_f);
    end

    // Merge: at most two text bytes per request in total
    nc = 2'(b_cnt + p_cnt);
    c0 = (b_cnt != 2'd0) ? b0 : p0;
    if (b_cnt == 2'd2)      c1 = b1;
    else if (b_cnt == 2'd1) c1 = p0;
    else                    c1 = p1;
    plan_any = (nc != 2'd0) | finish;

    phase_d    = finish ? dfn_pkg::PH_LEAD : ph_n;
    int_cnt_d  = finish ? 6'd0 : ic_n;
    frac_cnt_d = finish ? 5'd0 : fc_n;
    flags_d    = finish ? '0 : fl_n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dfn_pkg::PH_LEAD;
      int_cnt_q  <= 6'd0;
      frac_cnt_q <= 5'd0;
      flags_q    <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      int_cnt_q  <= int_cnt_d;
      frac_cnt_q <= frac_cnt_d;
      flags_q    <= flags_d;
    end
  end

  // Plan control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q  <= 1'b0;
      nc_q  <= 2'd0;
      pad_q <= 4'd0;
      fin_q <= 1'b0;
    end else if (in_fire) begin
      pv_q  <= plan_any;
      nc_q  <= nc;
      pad_q <= pad;
      fin_q <= finish;
    end else if (out_fire) begin
      if (last_beat) begin
        pv_q  <= 1'b0;
        nc_q  <= 2'd0;
        pad_q <= 4'd0;
        fin_q <= 1'b0;
      end else if (nc_q != 2'd0) begin
        nc_q <= nc_q - 2'd1;
      end else begin
        pad_q <= pad_q - 4'd1;
      end
    end
  end

  // Plan payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      c0_q <= c0;
      c1_q <= c1;
      st_q <= st;
    end else if (out_fire && nc_q != 2'd0) begin
      c0_q <= c1_q;
    end
  end

  logic text_beat;
  assign text_beat          = (nc_q != 2'd0) | (pad_q != 4'd0);
  assign out_o.valid        = pv_q;
  assign out_o.char_valid   = text_beat;
  assign out_o.end_of_field = ~text_beat;
  assign out_o.out_char     = (nc_q != 2'd0) ? c0_q :
                              (pad_q != 4'd0) ? dfn_pkg::ChZero : 8'd0;
  assign out_o.status       = text_beat ? 3'(dfn_pkg::ST_OK) : 3'(st_q);

endmodule

/* src/dfn_chk.sv */
// Checker: port-level properties of the decimal field normalizer, bound to the top level.
module dfn_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i,
  input logic       char_valid_i,
  input logic [2:0] status_i
);

  // Hold a stalled result until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_char_i) && $stable(char_valid_i) &&
                                    $stable(status_i))
    else $error("stalled result changed");

  // Input back-pressure only while results are pending
  a_ready_low_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("request refused with no result pending");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while result stalled");

endmodule

bind decimal_field_normalizer dfn_chk u_dfn_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_char_i   (out_o.out_char),
  .char_valid_i (out_o.char_valid),
  .status_i     (out_o.status)
);

/* tb/decimal_field_normalizer_tb.sv */
// Self-checking bench for the decimal field normalizer: random fields, stalls, live prediction.
module decimal_field_normalizer_tb;
  import dfn_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       empty;
    logic       last;
  } field_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       cv;
    logic       eof;
    status_e    st;
  } norm_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [4:0] cfg_wdata_i;

  dfn_in_if  in_bus ();
  dfn_out_if out_bus ();

  decimal_field_normalizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_bus),
    .out_o       (out_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Register copies as last written
  logic [3:0] cfg_scale   = FracScaleRst;
  logic [4:0] cfg_maxint  = MaxIntRst;
  logic       cfg_zero_ok = AllowZeroRst;

  // Parser state of the predictor
  phase_e     pr_phase = PH_LEAD;
  logic [5:0] pr_int   = '0;
  logic [4:0] pr_frac  = '0;
  flags_t     pr_flags = '0;

  field_req_t  field_q[$];
  norm_t       norm_q[$];
  field_req_t  cur_req = '0;
  bit          sending = 1'b0;
  bit          req_taken = 1'b0;
  bit          res_taken = 1'b0;
  bit          src_gaps_on = 1'b1;
  bit          snk_stalls_on = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned sent_count = 0;
  int unsigned mismatch_count = 0;

  function automatic int unsigned pick_wait(input bit on);
    if (!on) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic [3:0] scale_used();
    return (cfg_scale > MaxScale) ? 4'(MaxScale) : cfg_scale;
  endfunction

  function automatic bit int_len_over();
    logic [5:0] len;
    len = (pr_int == 6'd0) ? 6'd1 : pr_int;
    return len > {1'b0, cfg_maxint};
  endfunction

  // An error is already certain: text output stops for the rest of the field
  function automatic bit doomed();
    return pr_flags.neg || pr_flags.inval || int_len_over() || ({1'b0, pr_frac} > scale_used());
  endfunction

  task automatic put_norm(input logic [7:0] c, input logic cv, input logic eof, input status_e st);
    norm_q.insert(norm_q.size(), norm_t'{ch: c, cv: cv, eof: eof, st: st});
  endtask

  task automatic put_text(input logic [7:0] c);
    if (!doomed()) put_norm(c, 1'b1, 1'b0, ST_OK);
  endtask

  task automatic body_byte(input logic [7:0] c);
    if (c == ChDot) begin
      if (pr_flags.dot) begin
        pr_flags.inval = 1'b1;
      end else begin
        pr_flags.dot = 1'b1;
        if (!pr_flags.nzint) put_text(ChZero);
        put_text(ChDot);
      end
    end else if (c >= ChZero && c <= ChNine) begin
      if (!pr_flags.dot) begin
        // drop leading integer zeros
        if (pr_flags.nzint || c != ChZero) begin
          pr_flags.nzint = 1'b1;
          if (pr_int != 6'd63) pr_int = pr_int + 6'd1;
          put_text(c);
        end
      end else begin
        if (pr_frac != 5'd31) pr_frac = pr_frac + 5'd1;
        if (c != ChZero) pr_flags.nzfrac = 1'b1;
        put_text(c);
      end
    end else begin
      pr_flags.inval = 1'b1;
    end
  endtask

  task automatic first_byte(input logic [7:0] c);
    pr_flags.content = 1'b1;
    pr_phase = PH_BODY;
    if (c == ChMinus) pr_flags.neg = 1'b1;
    else body_byte(c);
  endtask

  task automatic close_field();
    status_e    st;
    logic [3:0] sc;
    int         i;
    sc = scale_used();
    if (!pr_flags.content) st = ST_EMPTY;
    else if (pr_flags.neg) st = ST_NEGATIVE;
    else if (pr_flags.inval) st = ST_INVALID;
    else if (int_len_over()) st = ST_TOO_LONG;
    else if ({1'b0, pr_frac} > sc) st = ST_TOO_FRAC;
    else if (!cfg_zero_ok && !pr_flags.nzint && !pr_flags.nzfrac) st = ST_ZERO;
    else st = ST_OK;
    if (st == ST_OK) begin
      if (!pr_flags.dot) begin
        if (!pr_flags.nzint) put_norm(ChZero, 1'b1, 1'b0, ST_OK);
        put_norm(ChDot, 1'b1, 1'b0, ST_OK);
      end
      // pad the fraction out to the scale
      for (i = pr_frac; i < sc; i++) put_norm(ChZero, 1'b1, 1'b0, ST_OK);
    end
    put_norm(8'h00, 1'b0, 1'b1, st);
    pr_phase = PH_LEAD;
    pr_int   = '0;
    pr_frac  = '0;
    pr_flags = '0;
  endtask

  task automatic normalize_step(input field_req_t r);
    if (r.empty) begin
      close_field();
    end else begin
      case (pr_phase)
        PH_LEAD: begin
          if (!is_blank(r.ch)) begin
            if (r.ch == ChPlus) pr_phase = PH_PLUS;
            else first_byte(r.ch);
          end
        end
        PH_PLUS: begin
          if (is_blank(r.ch)) pr_phase = PH_TRAIL;
          else first_byte(r.ch);
        end
        PH_BODY: begin
          if (is_blank(r.ch)) pr_phase = PH_TRAIL;
          else body_byte(r.ch);
        end
        default: begin
          if (!is_blank(r.ch)) begin
            pr_flags.content = 1'b1;
            pr_flags.inval   = 1'b1;
          end
        end
      endcase
      if (r.last) close_field();
    end
  endtask

  // Predict on each accepted request, then check each accepted result
  always @(posedge clk_i) begin : check_blk
    norm_t want;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready)
        normalize_step(field_req_t'{ch: in_bus.in_char, empty: in_bus.is_empty,
                                    last: in_bus.last});
      if (out_bus.valid && out_bus.ready) begin
        if (norm_q.size() == 0) begin
          $error("result with nothing expected: out_char %h eof %b status %0d",
                 out_bus.out_char, out_bus.end_of_field, out_bus.status);
          mismatch_count++;
        end else begin
          want = norm_q.pop_front();
          if (out_bus.out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_bus.out_char);
            mismatch_count++;
          end
          if (out_bus.char_valid !== want.cv) begin
            $error("char_valid: expected %b, got %b", want.cv, out_bus.char_valid);
            mismatch_count++;
          end
          if (out_bus.end_of_field !== want.eof) begin
            $error("end_of_field: expected %b, got %b", want.eof, out_bus.end_of_field);
            mismatch_count++;
          end
          if (out_bus.status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, out_bus.status);
            mismatch_count++;
          end
        end
      end
    end
    req_taken <= rst_ni && in_bus.valid && in_bus.ready;
    res_taken <= rst_ni && out_bus.valid && out_bus.ready;
  end

  // Request driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (sending && req_taken) sending = 1'b0;
      if (!sending) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end else if (field_q.size() != 0) begin
          cur_req  = field_q.pop_front();
          sending  = 1'b1;
          gap_left = pick_wait(src_gaps_on);
        end
      end
      in_bus.valid    <= sending;
      in_bus.in_char  <= cur_req.ch;
      in_bus.is_empty <= cur_req.empty;
      in_bus.last     <= cur_req.last;
    end
  end

  // Result sink: may stall after each result taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken) stall_left = pick_wait(snk_stalls_on);
      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  task automatic queue_byte(input logic [7:0] c, input logic last);
    field_q.insert(field_q.size(), field_req_t'{ch: c, empty: 1'b0, last: last});
    sent_count++;
  endtask

  task automatic queue_empty(input logic [7:0] c, input logic last);
    field_q.insert(field_q.size(), field_req_t'{ch: c, empty: 1'b1, last: last});
    sent_count++;
  endtask

  task automatic queue_text(input string s);
    foreach (s[i]) queue_byte(s[i], i == s.len() - 1);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0B;
      4: return 8'h0C;
      default: return 8'h0D;
    endcase
  endfunction

  function automatic logic [7:0] any_digit();
    return ($urandom_range(0, 2) == 0) ? ChZero : ChZero + 8'($urandom_range(0, 9));
  endfunction

  task automatic gen_field();
    logic [7:0]  txt[$];
    int unsigned n;
    if ($urandom_range(0, 11) == 0) begin
      // raw noise
      n = $urandom_range(1, 5);
      repeat (n) txt.insert(txt.size(), 8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) txt.insert(txt.size(), any_blank());
      case ($urandom_range(0, 11))
        0: txt.insert(txt.size(), ChPlus);
        1: txt.insert(txt.size(), ChMinus);
        default: ;
      endcase
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) txt.insert(txt.size(), ChZero);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cfg_maxint + 1) : $urandom_range(0, 3);
      repeat (n) txt.insert(txt.size(), any_digit());
      if ($urandom_range(0, 3) != 0) begin
        txt.insert(txt.size(), ChDot);
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cfg_scale + 1)
                                         : $urandom_range(0, cfg_scale);
        repeat (n) txt.insert(txt.size(), any_digit());
      end
      n = $urandom_range(0, 2);
      repeat (n) txt.insert(txt.size(), any_blank());
      // break a well-formed field now and then
      if (txt.size() != 0 && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(0, txt.size() - 1);
        case ($urandom_range(0, 4))
          0: txt[n] = ChDot;
          1: txt[n] = ChMinus;
          2: txt[n] = ChPlus;
          3: txt.insert(n, any_blank());
          default: txt[n] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    if (txt.size() == 0 || $urandom_range(0, 9) == 0) begin
      foreach (txt[i]) queue_byte(txt[i], 1'b0);
      queue_empty(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      foreach (txt[i]) queue_byte(txt[i], i == txt.size() - 1);
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [4:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_FRAC_SCALE: cfg_scale = val[3:0];
      CFG_MAX_INT:    cfg_maxint = val;
      default:        cfg_zero_ok = val[0];
    endcase
  endtask

  task automatic set_config(input int unsigned scale, input int unsigned maxint,
                            input int unsigned zero_ok);
    write_reg(CFG_FRAC_SCALE, 5'(scale));
    write_reg(CFG_MAX_INT, 5'(maxint));
    write_reg(CFG_ALLOW_ZERO, 5'(zero_ok));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold off until every request is taken and every result is in, then let the block settle
  task automatic drain();
    while (field_q.size() != 0 || sending || norm_q.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic random_fields(input int unsigned count, input bit partial_tail);
    int unsigned start;
    start = sent_count;
    while (sent_count - start < count) gen_field();
    // leave a field open so the next setting lands mid field
    if (partial_tail) queue_byte(ChZero + 8'($urandom_range(1, 9)), 1'b0);
    drain();
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = CFG_FRAC_SCALE;
    cfg_wdata_i        = '0;
    in_bus.valid       = 1'b0;
    in_bus.in_char     = '0;
    in_bus.is_empty    = 1'b0;
    in_bus.last        = 1'b0;
    out_bus.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed cases under reset settings
    queue_empty(8'h00, 1'b1);
    queue_text("-1");
    queue_text(".");
    queue_text("+.");
    queue_text("+ ");
    queue_text(".123");
    queue_text("1..");
    queue_text("1 2");
    queue_byte("5", 1'b0);
    queue_empty(8'hA5, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_text("\t0\n");
    drain();

    set_config(0, 1, 0);
    queue_text("12");
    queue_text("0.");
    queue_text("0.5");
    random_fields(45, 1'b1);

    set_config(15, 31, 1);
    random_fields(45, 1'b1);

    src_gaps_on   = 1'b0;
    snk_stalls_on = 1'b0;
    set_config($urandom_range(0, 15), $urandom_range(1, 31), $urandom_range(0, 1));
    random_fields(45, 1'b1);

    src_gaps_on   = 1'b1;
    snk_stalls_on = 1'b1;
    set_config($urandom_range(0, 15), $urandom_range(1, 31), $urandom_range(0, 1));
    random_fields(48, 1'b0);

    set_config(2, 18, 0);
    random_fields(48, 1'b0);

    if (mismatch_count == 0) begin
      $display("decimal_field_normalizer_tb: done, clean");
    end else begin
      $display("decimal_field_normalizer_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("decimal_field_normalizer_tb: done, errors");
    $finish;
  end

endmodule
